/* hdl/pfe_pkg.sv */
// Package for the postfix expression evaluator: constants, codes and types.
// Used by the datapath, controller, letter detector and top level; depends on nothing.
`default_nettype none
package pfe_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int WORD_W = 32;

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7a;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5a;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_MUL   = 8'h2a;
   localparam logic [7:0] CH_DIV   = 8'h2f;
   localparam logic [7:0] CH_POW   = 8'h5e;
   localparam logic [3:0] RADIX    = 4'd10;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_LETTER = 3'd1,
      ERR_UNDER  = 3'd2,
      ERR_OVER   = 3'd3,
      ERR_DIVZ   = 3'd4,
      ERR_EMPTY  = 3'd5
   } err_type;

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,     // waiting for a character
      ST_PUSHNUM,  // push the finished number
      ST_CLASSIFY, // decide on the character itself
      ST_RD1,      // read right operand
      ST_RD2,      // read left operand
      ST_LATCH,    // latch operands, start unit
      ST_EXEC,     // iterative divide or power
      ST_PUSHRES,  // push the result
      ST_FINPUSH,  // push pending number at the end
      ST_FINRD,    // read top for the result
      ST_FINOUT,   // load the output register
      ST_WAITOUT   // output register still full
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    load_char;
      logic    acc_digit;
      logic    push_acc;
      logic    push_res;
      logic    rd_top;     // read address count-1
      logic    rd_second;  // read address count-2
      logic    latch_rhs;
      logic    latch_lhs_start;
      logic    exec_step;
      logic    emit;
      logic    clear_all;
      logic    flag_letter;
      logic    flag_under;
   } cmd_type;

   // Status back to the controller.
   typedef struct packed {
      logic    is_digit;
      logic    is_op;
      logic    in_number;
      logic    last;
      logic    count_lt2;
      logic    exec_done;
      logic    out_full;
   } sts_type;

endpackage
`default_nettype wire

/* hdl/pfe_stream_if.sv */
// Valid/ready channel interface used on both sides of the evaluator.
// Payload width is a parameter; no package dependency.
`default_nettype none
interface pfe_stream_if #(parameter int W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hdl/pfe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`default_nettype none
module pfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hdl/pfe_datapath.sv */
// Datapath: character register, number builder, value stack, the arithmetic
// unit (iterative divider and power), error register and output register.
// Depends on pfe_pkg and pfe_ram.
`default_nettype none
module pfe_datapath #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [7:0]      in_char,
   input  wire logic            in_last,
   input  wire pfe_pkg::cmd_type cmd,
   output pfe_pkg::sts_type     sts,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output logic [31:0]          out_value,
   output logic [2:0]           out_error
);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

   logic [7:0]    char_ff;
   logic          last_ff;
   logic [31:0]   acc_ff;
   logic          innum_ff;
   logic [CW-1:0] count_ff;
   logic [2:0]    err_ff;
   logic [31:0]   rhs_ff, lhs_ff;
   pfe_pkg::op_type op_ff;
   logic [31:0]   res_ff;
   logic [5:0]    step_ff;
   logic          busy_ff;
   // divider
   logic [31:0]   rem_ff, quo_ff, dvs_ff;
   logic          qneg_ff, rneg_ff;
   // power
   logic [31:0]   pb_ff, pe_ff;
   logic          pphase_ff; // 0: r*=b step, 1: b*=b step
   logic          out_valid_ff;
   logic [31:0]   out_value_ff;
   logic [2:0]    out_error_ff;

   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;
   logic          wr_en;
   logic [31:0]   wr_data;
   logic          is_digit, is_op, full;

   assign is_digit = (char_ff >= pfe_pkg::CH_0) && (char_ff <= pfe_pkg::CH_9);
   assign is_op = (char_ff == pfe_pkg::CH_PLUS) || (char_ff == pfe_pkg::CH_MINUS) ||
                  (char_ff == pfe_pkg::CH_MUL)  || (char_ff == pfe_pkg::CH_DIV) ||
                  (char_ff == pfe_pkg::CH_POW);
   assign full = (count_ff >= FULL);

   assign sts.is_digit  = is_digit;
   assign sts.is_op     = is_op;
   assign sts.in_number = innum_ff;
   assign sts.last      = last_ff;
   assign sts.count_lt2 = (count_ff < CW'(2));
   assign sts.exec_done = !busy_ff;
   assign sts.out_full  = out_valid_ff;

   always_comb begin
      if (cmd.rd_second) rd_addr = AW'(count_ff - CW'(2));
      else               rd_addr = AW'(count_ff - CW'(1));
   end

   assign wr_en   = (cmd.push_acc || cmd.push_res) && !full;
   assign wr_data = cmd.push_acc ? acc_ff : res_ff;

   pfe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(count_ff)),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   function automatic logic [31:0] neg_abs(input logic [31:0] x);
      neg_abs = x[31] ? (~x + 32'd1) : x;
   endfunction

   logic [32:0] trial;
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         innum_ff     <= 1'b0;
         count_ff     <= '0;
         err_ff       <= pfe_pkg::ERR_NONE;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         if (cmd.load_char) begin
            char_ff <= in_char;
            last_ff <= in_last;
         end
         if (cmd.acc_digit) begin
            acc_ff   <= 32'(acc_ff * 32'(pfe_pkg::RADIX)) + 32'(char_ff - pfe_pkg::CH_0);
            innum_ff <= 1'b1;
         end
         if (cmd.push_acc) begin
            acc_ff   <= '0;
            innum_ff <= 1'b0;
         end
         if (cmd.push_acc || cmd.push_res) begin
            if (full) begin
               if (err_ff == pfe_pkg::ERR_NONE) err_ff <= pfe_pkg::ERR_OVER;
            end else begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (cmd.flag_letter && err_ff == pfe_pkg::ERR_NONE) err_ff <= pfe_pkg::ERR_LETTER;
         if (cmd.flag_under && err_ff == pfe_pkg::ERR_NONE) err_ff <= pfe_pkg::ERR_UNDER;
         if (cmd.latch_rhs) rhs_ff <= rd_data;
         if (cmd.latch_lhs_start) begin
            lhs_ff   <= rd_data;
            count_ff <= count_ff - CW'(2);
            busy_ff  <= 1'b0;
            unique case (char_ff)
               pfe_pkg::CH_PLUS: begin
                  op_ff <= pfe_pkg::OP_ADD; res_ff <= rd_data + rhs_ff;
               end
               pfe_pkg::CH_MINUS: begin
                  op_ff <= pfe_pkg::OP_SUB; res_ff <= rd_data - rhs_ff;
               end
               pfe_pkg::CH_MUL: begin
                  op_ff <= pfe_pkg::OP_MUL; res_ff <= 32'(rd_data * rhs_ff);
               end
               pfe_pkg::CH_DIV: begin
                  op_ff <= pfe_pkg::OP_DIV;
                  res_ff <= '0;
                  if (rhs_ff == '0) begin
                     if (err_ff == pfe_pkg::ERR_NONE) err_ff <= pfe_pkg::ERR_DIVZ;
                  end else begin
                     busy_ff <= 1'b1;
                     step_ff <= 6'd32;
                     rem_ff  <= '0;
                     quo_ff  <= neg_abs(rd_data);
                     dvs_ff  <= neg_abs(rhs_ff);
                     qneg_ff <= rd_data[31] ^ rhs_ff[31];
                  end
               end
               default: begin
                  op_ff <= pfe_pkg::OP_POW;
                  if (rhs_ff[31]) begin
                     if (rd_data == 32'd1) res_ff <= 32'd1;
                     else if (rd_data == '1) res_ff <= rhs_ff[0] ? '1 : 32'd1;
                     else res_ff <= '0;
                  end else begin
                     res_ff    <= 32'd1;
                     pb_ff     <= rd_data;
                     pe_ff     <= rhs_ff;
                     pphase_ff <= 1'b0;
                     busy_ff   <= (rhs_ff != '0);
                  end
               end
            endcase
         end
         if (cmd.exec_step && busy_ff) begin
            if (op_ff == pfe_pkg::OP_DIV) begin
               // One restoring-division step per cycle on magnitudes.
               if (!trial[32]) begin
                  rem_ff <= trial[31:0];
                  quo_ff <= {quo_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[30:0], quo_ff[31]};
                  quo_ff <= {quo_ff[30:0], 1'b0};
               end
               step_ff <= step_ff - 6'd1;
               if (step_ff == 6'd1) busy_ff <= 1'b0;
               if (step_ff == 6'd0) busy_ff <= 1'b0;
            end else begin
               // Square-and-multiply, one multiplication per cycle.
               if (!pphase_ff) begin
                  if (pe_ff[0]) res_ff <= 32'(res_ff * pb_ff);
                  pphase_ff <= 1'b1;
               end else begin
                  pb_ff     <= 32'(pb_ff * pb_ff);
                  pe_ff     <= pe_ff >> 1;
                  pphase_ff <= 1'b0;
                  if (pe_ff[31:1] == '0) busy_ff <= 1'b0;
               end
            end
         end
         if (cmd.push_res && op_ff == pfe_pkg::OP_DIV && rhs_ff != '0) begin
            // Result written below uses the signed quotient.
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
            if (count_ff == '0) begin
               out_value_ff <= '0;
               out_error_ff <= (err_ff == pfe_pkg::ERR_NONE) ? pfe_pkg::ERR_EMPTY : err_ff;
            end else begin
               out_value_ff <= rd_data;
               out_error_ff <= err_ff;
            end
         end
         if (cmd.clear_all) begin
            acc_ff   <= '0;
            innum_ff <= 1'b0;
            count_ff <= '0;
            err_ff   <= pfe_pkg::ERR_NONE;
         end
         if (op_ff == pfe_pkg::OP_DIV && !busy_ff && step_ff == 6'd0 && cmd.exec_step) begin
            res_ff  <= qneg_ff ? (~quo_ff + 32'd1) : quo_ff;
            step_ff <= 6'd63;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_error = out_error_ff;
   logic unused_rneg;
   always_ff @(posedge clock) rneg_ff <= 1'b0;
   assign unused_rneg = rneg_ff;
endmodule
`default_nettype wire

/* hdl/pfe_control.sv */
// Controller state machine for the evaluator; sequences one character at
// a time through the datapath. Depends on pfe_pkg.
`default_nettype none
module pfe_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire pfe_pkg::sts_type sts,
   output pfe_pkg::cmd_type      cmd
);
   pfe_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pfe_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfe_pkg::ST_IDLE:     if (in_valid) state_in = pfe_pkg::ST_CLASSIFY;
         pfe_pkg::ST_CLASSIFY: begin
            if (sts.is_digit)       state_in = pfe_pkg::ST_FINPUSH;
            else if (sts.in_number) state_in = pfe_pkg::ST_PUSHNUM;
            else if (sts.is_op)     state_in = pfe_pkg::ST_RD1;
            else                    state_in = pfe_pkg::ST_FINPUSH;
         end
         pfe_pkg::ST_PUSHNUM:  state_in = sts.is_op ? pfe_pkg::ST_RD1 : pfe_pkg::ST_FINPUSH;
         pfe_pkg::ST_RD1:      state_in = sts.count_lt2 ? pfe_pkg::ST_FINPUSH : pfe_pkg::ST_RD2;
         pfe_pkg::ST_RD2:      state_in = pfe_pkg::ST_LATCH;
         pfe_pkg::ST_LATCH:    state_in = pfe_pkg::ST_EXEC;
         pfe_pkg::ST_EXEC:     if (sts.exec_done) state_in = pfe_pkg::ST_PUSHRES;
         pfe_pkg::ST_PUSHRES:  state_in = pfe_pkg::ST_FINPUSH;
         pfe_pkg::ST_FINPUSH:  state_in = sts.last ? pfe_pkg::ST_FINRD : pfe_pkg::ST_IDLE;
         pfe_pkg::ST_FINRD:    state_in = pfe_pkg::ST_WAITOUT;
         pfe_pkg::ST_WAITOUT:  if (!sts.out_full) state_in = pfe_pkg::ST_FINOUT;
         pfe_pkg::ST_FINOUT:   state_in = pfe_pkg::ST_IDLE;
         default:              state_in = pfe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         pfe_pkg::ST_IDLE: begin
            in_ready      = 1'b1;
            cmd.load_char = in_valid;
         end
         pfe_pkg::ST_CLASSIFY: begin
            cmd.acc_digit   = sts.is_digit;
            cmd.flag_letter = 1'b0;
         end
         pfe_pkg::ST_PUSHNUM: cmd.push_acc = 1'b1;
         pfe_pkg::ST_RD1: begin
            cmd.rd_top     = 1'b1;
            cmd.flag_under = sts.count_lt2;
         end
         pfe_pkg::ST_RD2: begin
            cmd.rd_second = 1'b1;
            cmd.latch_rhs = 1'b1;
         end
         pfe_pkg::ST_LATCH: cmd.latch_lhs_start = 1'b1;
         pfe_pkg::ST_EXEC:    cmd.exec_step = 1'b1;
         pfe_pkg::ST_PUSHRES: cmd.push_res = 1'b1;
         pfe_pkg::ST_FINPUSH: cmd.push_acc = sts.last && sts.in_number;
         pfe_pkg::ST_FINRD:   cmd.rd_top = 1'b1;
         pfe_pkg::ST_WAITOUT: cmd.rd_top = 1'b1;
         pfe_pkg::ST_FINOUT: begin
            cmd.emit      = 1'b1;
            cmd.clear_all = 1'b1;
         end
         default: cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

/* hdl/pfe_classify.sv */
// Letter detector: flags alphabetic characters of a transaction.
// Depends on pfe_pkg.
`default_nettype none
module pfe_classify (
   input  wire logic [7:0] char_code,
   output logic            is_letter
);
   assign is_letter =
      ((char_code >= pfe_pkg::CH_LA) && (char_code <= pfe_pkg::CH_LZ)) ||
      ((char_code >= pfe_pkg::CH_UA) && (char_code <= pfe_pkg::CH_UZ));
endmodule
`default_nettype wire

/* hdl/postfix_expression_evaluator.sv */
// Postfix expression evaluator, one ASCII character per request transaction.
// A response transaction carries the stack top and sticky error code; it is
// produced only for a character marked last, after which all state clears.
// Division computes one quotient bit per cycle in the iterative divider; ^
// is computed in the square-and-multiply unit. A last character also passes
// through the final read, output-wait and output-load states.
// One character is processed at a time; req_ready is high only when idle.
// The response sits in an output register; while the receiver stalls,
// the next expression proceeds until its own final result must be loaded.
// Reset (synchronous, active high) empties the stack, clears the number
// builder and the error code, and drops any pending response.
// Depends on pfe_pkg, pfe_stream_if, pfe_ram, pfe_datapath, pfe_control, pfe_classify.
`default_nettype none
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pfe_stream_if.sink   req,
   pfe_stream_if.source rsp
);
   pfe_pkg::cmd_type cmd, cmd_fix;
   pfe_pkg::sts_type sts;
   logic             is_letter;
   logic [7:0]       char_q;

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) char_q <= req.payload[7:0];
   end

   pfe_classify u_cls (.char_code(char_q), .is_letter(is_letter));

   pfe_control u_ctl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .sts(sts), .cmd(cmd)
   );

   always_comb begin
      cmd_fix = cmd;
      // Letters are checked once, in the cycle after acceptance.
      cmd_fix.flag_letter = cmd.acc_digit | (is_letter & ~sts.is_digit & letter_chk);
      cmd_fix.acc_digit   = cmd.acc_digit;
      if (cmd.acc_digit) cmd_fix.flag_letter = 1'b0;
   end

   logic letter_chk;
   always_ff @(posedge clock) begin
      if (reset) letter_chk <= 1'b0;
      else       letter_chk <= req.valid && req.ready;
   end

   pfe_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock(clock), .reset(reset),
      .in_char(req.payload[7:0]), .in_last(req.payload[8]),
      .cmd(cmd_fix), .sts(sts),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_value(rsp.payload[31:0]), .out_error(rsp.payload[34:32])
   );
endmodule
`default_nettype wire
